FILE: src/mtgl_pkg.sv
// Package for the monospace text glyph layout block.
// Holds character codes, register indexes, code classes and the queue word type.
// No dependencies.
package mtgl_pkg;

  localparam logic [7:0] CODE_BS    = 8'h08;
  localparam logic [7:0] CODE_TAB   = 8'h09;
  localparam logic [7:0] CODE_LF    = 8'h0A;
  localparam logic [7:0] CODE_CR    = 8'h0D;
  localparam logic [7:0] CODE_SPACE = 8'h20;
  localparam logic [7:0] CODE_DEL   = 8'h7F;
  localparam logic [7:0] CODE_FF    = 8'hFF;

  localparam logic [5:0] CELL_MAX   = 6'd32;
  localparam logic [5:0] CELL_MIN   = 6'd1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_GLYPH_WIDTH  = 3'd2,
    CFG_GLYPH_HEIGHT = 3'd3,
    CFG_CHAR_SPACING = 3'd4,
    CFG_LINE_SPACING = 3'd5,
    CFG_TAB_COLUMNS  = 3'd6,
    CFG_BACK_ENABLE  = 3'd7
  } mtgl_cfg_t;

  typedef enum logic [2:0] {
    CLS_PRINT,
    CLS_LF,
    CLS_CR,
    CLS_BS,
    CLS_TAB,
    CLS_IGNORE
  } mtgl_cls_t;

  typedef struct packed {
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic [3:0]  col;
    logic [3:0]  row;
    logic [5:0]  w;
    logic [5:0]  h;
    logic        back;
  } mtgl_word_t;

  function automatic logic [5:0] clamp_cell(input logic [5:0] v);
    logic [5:0] r;
    if (v == 6'd0) begin
      r = CELL_MIN;
    end else if (v > CELL_MAX) begin
      r = CELL_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic mtgl_cls_t classify(input logic [7:0] code);
    mtgl_cls_t c;
    priority if (code == CODE_LF) begin
      c = CLS_LF;
    end else if (code == CODE_CR) begin
      c = CLS_CR;
    end else if (code == CODE_BS) begin
      c = CLS_BS;
    end else if (code == CODE_TAB) begin
      c = CLS_TAB;
    end else if (code < CODE_SPACE || code == CODE_DEL || code == CODE_FF) begin
      c = CLS_IGNORE;
    end else begin
      c = CLS_PRINT;
    end
    return c;
  endfunction

endpackage

FILE: src/mtgl_front.sv
// Front end: configuration registers, code classification and pen update.
// Emits one queue word per printable code. Depends on mtgl_pkg.
module mtgl_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mtgl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mtgl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             take,
  input  logic [7:0]                       char_code,
  input  logic                             first,
  output logic                             q_push,
  output mtgl_pkg::mtgl_word_t             q_word
);
  import mtgl_pkg::*;

  logic [15:0] origin_x_r;
  logic [15:0] origin_y_r;
  logic [5:0]  glyph_width_r;
  logic [5:0]  glyph_height_r;
  logic [7:0]  char_spacing_r;
  logic [7:0]  line_spacing_r;
  logic [3:0]  tab_columns_r;
  logic        back_enable_r;
  logic [15:0] pen_x_r, pen_x_nxt;
  logic [15:0] pen_y_r, pen_y_nxt;

  logic [5:0]  w, h;
  logic [15:0] w16, h16, hsp, vsp, base_x, base_y, tab_adv;
  logic [9:0]  tab_prod;
  mtgl_cls_t   cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      glyph_width_r  <= 6'd8;
      glyph_height_r <= 6'd8;
      char_spacing_r <= '0;
      line_spacing_r <= '0;
      tab_columns_r  <= 4'd4;
      back_enable_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (mtgl_cfg_t'(cfg_index))
        CFG_ORIGIN_X:     origin_x_r     <= cfg_data;
        CFG_ORIGIN_Y:     origin_y_r     <= cfg_data;
        CFG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data[5:0];
        CFG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[5:0];
        CFG_CHAR_SPACING: char_spacing_r <= cfg_data[7:0];
        CFG_LINE_SPACING: line_spacing_r <= cfg_data[7:0];
        CFG_TAB_COLUMNS:  tab_columns_r  <= cfg_data[3:0];
        CFG_BACK_ENABLE:  back_enable_r  <= cfg_data[0];
      endcase
    end
  end

  always_comb begin
    w        = clamp_cell(glyph_width_r);
    h        = clamp_cell(glyph_height_r);
    w16      = {10'd0, w};
    h16      = {10'd0, h};
    hsp      = {{8{char_spacing_r[7]}}, char_spacing_r};
    vsp      = {{8{line_spacing_r[7]}}, line_spacing_r};
    tab_prod = 10'(w) * 10'(tab_columns_r);
    tab_adv  = {6'd0, tab_prod};
    base_x   = first ? origin_x_r : pen_x_r;
    base_y   = first ? origin_y_r : pen_y_r;
    cls      = classify(char_code);
    pen_x_nxt = base_x;
    pen_y_nxt = base_y;
    unique case (cls)
      CLS_LF: begin
        pen_x_nxt = origin_x_r;
        pen_y_nxt = base_y + h16 + vsp;
      end
      CLS_CR:     pen_x_nxt = origin_x_r;
      CLS_BS:     pen_x_nxt = base_x - w16 - hsp;
      CLS_TAB:    pen_x_nxt = base_x + tab_adv + hsp;
      CLS_PRINT:  pen_x_nxt = base_x + w16 + hsp;
      CLS_IGNORE: pen_x_nxt = base_x;
      default:    pen_x_nxt = base_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else if (take) begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

  assign q_push       = take && (cls == CLS_PRINT);
  assign q_word.pen_x = base_x;
  assign q_word.pen_y = base_y;
  assign q_word.col   = char_code[3:0];
  assign q_word.row   = char_code[7:4];
  assign q_word.w     = w;
  assign q_word.h     = h;
  assign q_word.back  = back_enable_r;

endmodule

FILE: src/mtgl_queue.sv
// Short queue between front and back end.
// Register array with read and write pointers. Depends on mtgl_pkg.
module mtgl_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mtgl_pkg::mtgl_word_t din,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output mtgl_pkg::mtgl_word_t dout
);
  import mtgl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mtgl_word_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: src/mtgl_back.sv
// Back end: builds screen and atlas quads from queue words into an output register.
// Depends on mtgl_pkg.
module mtgl_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  mtgl_pkg::mtgl_word_t q_word,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output logic signed [15:0]   x_left,
  output logic signed [15:0]   y_top,
  output logic signed [15:0]   x_right,
  output logic signed [15:0]   y_bottom,
  output logic [8:0]           u_left,
  output logic [8:0]           v_top,
  output logic [9:0]           u_right,
  output logic [9:0]           v_bottom,
  output logic                 back_quad
);
  import mtgl_pkg::*;

  logic        vld_r;
  logic [15:0] x_l_r, y_t_r, x_r_r, y_b_r;
  logic [8:0]  u_l_r, v_t_r;
  logic [9:0]  u_r_r, v_b_r;
  logic        back_r;
  logic [9:0]  u_prod, v_prod;

  assign q_pop  = q_valid && (!vld_r || pop);
  assign u_prod = 10'(q_word.col) * 10'(q_word.w);
  assign v_prod = 10'(q_word.row) * 10'(q_word.h);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
    end else if (pop) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_l_r  <= q_word.pen_x;
      y_t_r  <= q_word.pen_y;
      x_r_r  <= q_word.pen_x + {10'd0, q_word.w};
      y_b_r  <= q_word.pen_y + {10'd0, q_word.h};
      u_l_r  <= u_prod[8:0];
      v_t_r  <= v_prod[8:0];
      u_r_r  <= u_prod + 10'(q_word.w);
      v_b_r  <= v_prod + 10'(q_word.h);
      back_r <= q_word.back;
    end
  end

  assign empty     = !vld_r;
  assign x_left    = x_l_r;
  assign y_top     = y_t_r;
  assign x_right   = x_r_r;
  assign y_bottom  = y_b_r;
  assign u_left    = u_l_r;
  assign v_top     = v_t_r;
  assign u_right   = u_r_r;
  assign v_bottom  = v_b_r;
  assign back_quad = back_r;

endmodule

FILE: src/monospace_text_glyph_layout.sv
// Monospace text glyph layout: one character word per cycle in while full is low, one
// quad word out per printable code. A pushed word passes the queue and then the output
// register before it shows on the result ports; throughput is one word per cycle while
// full is low, set by the pen update register.
// full rises only when the front-to-back queue is filled by a stalled consumer.
// rst_n is synchronous, active low: pen cleared, registers at defaults, queue empty.
module monospace_text_glyph_layout #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mtgl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mtgl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       in_char_code,
  input  logic                             in_first,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [15:0]               out_x_left,
  output logic signed [15:0]               out_y_top,
  output logic signed [15:0]               out_x_right,
  output logic signed [15:0]               out_y_bottom,
  output logic [8:0]                       out_u_left,
  output logic [8:0]                       out_v_top,
  output logic [9:0]                       out_u_right,
  output logic [9:0]                       out_v_bottom,
  output logic                             out_back_quad
);
  import mtgl_pkg::*;

  logic       take;
  logic       q_push, q_full, q_valid, q_pop;
  mtgl_word_t q_din, q_dout;

  assign full = q_full;
  assign take = push && !q_full;

  mtgl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .char_code (in_char_code),
    .first     (in_first),
    .q_push    (q_push),
    .q_word    (q_din)
  );

  mtgl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  mtgl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_dout),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .x_left    (out_x_left),
    .y_top     (out_y_top),
    .x_right   (out_x_right),
    .y_bottom  (out_y_bottom),
    .u_left    (out_u_left),
    .v_top     (out_v_top),
    .u_right   (out_u_right),
    .v_bottom  (out_v_bottom),
    .back_quad (out_back_quad)
  );

endmodule

FILE: src/mtgl_chk.sv
// Port-level checker for the monospace text glyph layout block, bound to the top level.
// Watches the result side only; no package dependency.
module mtgl_chk (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             empty,
  input  logic                             pop,
  input  logic signed [15:0]               out_x_left,
  input  logic signed [15:0]               out_y_top,
  input  logic signed [15:0]               out_x_right,
  input  logic signed [15:0]               out_y_bottom,
  input  logic [8:0]                       out_u_left,
  input  logic [8:0]                       out_v_top,
  input  logic [9:0]                       out_u_right,
  input  logic [9:0]                       out_v_bottom,
  input  logic                             out_back_quad
);

  logic [15:0] dx, dy;
  logic [9:0]  du, dv;

  assign dx = out_x_right - out_x_left;
  assign dy = out_y_bottom - out_y_top;
  assign du = out_u_right - {1'b0, out_u_left};
  assign dv = out_v_bottom - {1'b0, out_v_top};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_x_left) && $stable(out_u_left)
                          && $stable(out_back_quad)))
    else $error("waiting word changed before pop");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (dx >= 16'd1 && dx <= 16'd32 && dy >= 16'd1 && dy <= 16'd32))
    else $error("quad extent outside one glyph cell");

  a_u_matches_x: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (du == dx[9:0]))
    else $error("atlas width differs from screen width");

  a_v_matches_y: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (dv == dy[9:0]))
    else $error("atlas height differs from screen height");

endmodule

bind monospace_text_glyph_layout mtgl_chk u_mtgl_chk (.*);

FILE: test/testbench.sv
// Testbench for monospace_text_glyph_layout: drives character words through the
// push/full queue, predicts pen movement and glyph quads, checks every popped word.
// Depends on mtgl_pkg and the block's top level only.
module testbench;
  import mtgl_pkg::*;

  typedef struct packed {
    logic [15:0] x_left;
    logic [15:0] y_top;
    logic [15:0] x_right;
    logic [15:0] y_bottom;
    logic [8:0]  u_left;
    logic [8:0]  v_top;
    logic [9:0]  u_right;
    logic [9:0]  v_bottom;
    logic        back_quad;
  } quad_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  push;
  logic                  full;
  logic [7:0]            in_char_code;
  logic                  in_first;
  logic                  empty;
  logic                  pop;
  logic signed [15:0]    out_x_left;
  logic signed [15:0]    out_y_top;
  logic signed [15:0]    out_x_right;
  logic signed [15:0]    out_y_bottom;
  logic [8:0]            out_u_left;
  logic [8:0]            out_v_top;
  logic [9:0]            out_u_right;
  logic [9:0]            out_v_bottom;
  logic                  out_back_quad;

  // layout state and register copies
  logic [15:0] cur_x, cur_y;
  logic [15:0] org_x, org_y;
  logic [5:0]  cell_w, cell_h;
  logic [7:0]  gap_x, gap_y;
  logic [3:0]  tab_cols;
  logic        back_on;

  quad_t pending_quads[$];
  int    mismatches;
  bit    steady;
  int    pop_hold;

  monospace_text_glyph_layout u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .in_char_code (in_char_code),
    .in_first     (in_first),
    .empty        (empty),
    .pop          (pop),
    .out_x_left   (out_x_left),
    .out_y_top    (out_y_top),
    .out_x_right  (out_x_right),
    .out_y_bottom (out_y_bottom),
    .out_u_left   (out_u_left),
    .out_v_top    (out_v_top),
    .out_u_right  (out_u_right),
    .out_v_bottom (out_v_bottom),
    .out_back_quad(out_back_quad)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [15:0] cell_size(input logic [5:0] v);
    logic [15:0] r;
    if (v == 6'd0) begin
      r = 16'd1;
    end else if (v > 6'd32) begin
      r = 16'd32;
    end else begin
      r = {10'd0, v};
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic layout_char(input logic [7:0] code, input logic first);
    logic [15:0] w, h, hsp, vsp;
    quad_t q;
    w   = cell_size(cell_w);
    h   = cell_size(cell_h);
    hsp = {{8{gap_x[7]}}, gap_x};
    vsp = {{8{gap_y[7]}}, gap_y};
    if (first) begin
      cur_x = org_x;
      cur_y = org_y;
    end
    case (code)
      CODE_LF: begin
        cur_x = org_x;
        cur_y = cur_y + h + vsp;
      end
      CODE_CR: begin
        cur_x = org_x;
      end
      CODE_BS: begin
        cur_x = cur_x - w - hsp;
      end
      CODE_TAB: begin
        cur_x = cur_x + w * tab_cols + hsp;
      end
      default: begin
        if (code >= CODE_SPACE && code != CODE_DEL && code != CODE_FF) begin
          q.x_left    = cur_x;
          q.y_top     = cur_y;
          q.x_right   = cur_x + w;
          q.y_bottom  = cur_y + h;
          q.u_left    = 9'(code[3:0] * w);
          q.v_top     = 9'(code[7:4] * h);
          q.u_right   = 10'(code[3:0] * w + w);
          q.v_bottom  = 10'(code[7:4] * h + h);
          q.back_quad = back_on;
          pending_quads.push_back(q);
          cur_x = cur_x + w + hsp;
        end
      end
    endcase
  endtask

  // hold cfg_we high across a batch; the caller lowers it
  task automatic write_reg(input mtgl_cfg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_ORIGIN_X:     org_x    = val;
      CFG_ORIGIN_Y:     org_y    = val;
      CFG_GLYPH_WIDTH:  cell_w   = val[5:0];
      CFG_GLYPH_HEIGHT: cell_h   = val[5:0];
      CFG_CHAR_SPACING: gap_x    = val[7:0];
      CFG_LINE_SPACING: gap_y    = val[7:0];
      CFG_TAB_COLUMNS:  tab_cols = val[3:0];
      CFG_BACK_ENABLE:  back_on  = val[0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [15:0] ox, input logic [15:0] oy,
                           input logic [5:0] gw, input logic [5:0] gh,
                           input logic [7:0] cs, input logic [7:0] ls,
                           input logic [3:0] tc, input logic be);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_GLYPH_WIDTH, {10'd0, gw});
    write_reg(CFG_GLYPH_HEIGHT, {10'd0, gh});
    write_reg(CFG_CHAR_SPACING, {8'd0, cs});
    write_reg(CFG_LINE_SPACING, {8'd0, ls});
    write_reg(CFG_TAB_COLUMNS, {12'd0, tc});
    write_reg(CFG_BACK_ENABLE, {15'd0, be});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_char(input logic [7:0] code, input logic first);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push         <= 1'b1;
    in_char_code <= code;
    in_first     <= first;
    @(posedge clk);
    while (full) @(posedge clk);
    layout_char(code, first);
  endtask

  // drop push, wait for every quad, then let the pipe settle
  task automatic drain_wait();
    @(negedge clk);
    push <= 1'b0;
    while (pending_quads.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_line(input int len);
    logic [7:0] c;
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        c = 8'($urandom_range(8'h20, 8'h7E));
      end else if (r < 80) begin
        c = 8'($urandom_range(8'h80, 8'hFE));
      end else if (r < 90) begin
        case ($urandom_range(0, 3))
          0: c = CODE_LF;
          1: c = CODE_CR;
          2: c = CODE_BS;
          default: c = CODE_TAB;
        endcase
      end else begin
        c = 8'($urandom_range(0, 255));
      end
      send_char(c, i == 0 || $urandom_range(0, 49) == 0);
    end
  endtask

  function automatic logic [15:0] pick_origin();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [5:0] pick_cell();
    case ($urandom_range(0, 7))
      0: return 6'd0;
      1: return 6'($urandom_range(33, 63));
      2: return 6'd32;
      3: return 6'd1;
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  function automatic logic [7:0] pick_spacing();
    case ($urandom_range(0, 5))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_char("A", 1'b1);
    send_char(8'h20, 1'b0);
    send_char(8'h7E, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hFE, 1'b0);
    send_char(CODE_BS, 1'b0);
    send_char(CODE_TAB, 1'b0);
    send_char(CODE_CR, 1'b0);
    send_char(CODE_LF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h1F, 1'b0);
    send_char(CODE_DEL, 1'b0);
    send_char(CODE_FF, 1'b0);
    send_char(8'h00, 1'b1);
    send_char("B", 1'b0);
    drain_wait();
  endtask

  task automatic test_size_extremes();
    load_regs(16'h7FFF, 16'h8000, 6'd0, 6'd63, 8'h7F, 8'h80, 4'd15, 1'b1);
    send_char(8'h41, 1'b1);
    send_char(8'hFE, 1'b0);
    send_char(CODE_TAB, 1'b0);
    send_char(CODE_BS, 1'b0);
    send_char(CODE_LF, 1'b0);
    drain_wait();
    load_regs(16'h8000, 16'h7FFF, 6'd32, 6'd32, 8'h80, 8'h7F, 4'd0, 1'b0);
    send_char(8'hFE, 1'b1);
    send_char(CODE_TAB, 1'b0);
    send_char(CODE_LF, 1'b0);
    send_char(8'h20, 1'b0);
    drain_wait();
  endtask

  task automatic test_random_text();
    int sent;
    for (int p = 0; p < 9; p++) begin
      load_regs(pick_origin(), pick_origin(), pick_cell(), pick_cell(), pick_spacing(),
                pick_spacing(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      sent = 0;
      while (sent < 70) begin
        send_line($urandom_range(1, 24));
        sent += 12;
        // at random, hold the sender until every quad has come
        if ($urandom_range(0, 4) == 0) begin
          drain_wait();
        end
      end
      drain_wait();
    end
  endtask

  task automatic test_back_to_back();
    load_regs(pick_origin(), pick_origin(), 6'($urandom_range(1, 32)),
              6'($urandom_range(1, 32)), pick_spacing(), pick_spacing(),
              4'($urandom_range(0, 15)), 1'b1);
    steady = 1'b1;
    send_line(30);
    send_line(20);
    steady = 1'b0;
    send_line(20);
    drain_wait();
  endtask

  always @(negedge clk) begin
    if (steady) begin
      pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        pop_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    quad_t q;
    if (rst_n && pop && !empty) begin
      if (pending_quads.size() == 0) begin
        $display("%0t: unexpected word, expected none, got x_left %0h", $time, out_x_left);
        mismatches++;
      end else begin
        q = pending_quads.pop_front();
        check_field("x_left", q.x_left, out_x_left);
        check_field("y_top", q.y_top, out_y_top);
        check_field("x_right", q.x_right, out_x_right);
        check_field("y_bottom", q.y_bottom, out_y_bottom);
        check_field("u_left", {7'd0, q.u_left}, {7'd0, out_u_left});
        check_field("v_top", {7'd0, q.v_top}, {7'd0, out_v_top});
        check_field("u_right", {6'd0, q.u_right}, {6'd0, out_u_right});
        check_field("v_bottom", {6'd0, q.v_bottom}, {6'd0, out_v_bottom});
        check_field("back_quad", {15'd0, q.back_quad}, {15'd0, out_back_quad});
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_ORIGIN_X;
    cfg_data     = '0;
    push         = 1'b0;
    in_char_code = '0;
    in_first     = 1'b0;
    pop          = 1'b0;
    pop_hold     = 0;
    steady       = 1'b0;
    mismatches   = 0;
    cur_x        = '0;
    cur_y        = '0;
    org_x        = '0;
    org_y        = '0;
    cell_w       = 6'd8;
    cell_h       = 6'd8;
    gap_x        = '0;
    gap_y        = '0;
    tab_cols     = 4'd4;
    back_on      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_size_extremes();
    test_random_text();
    test_back_to_back();
    drain_wait();
    if (mismatches == 0 && pending_quads.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
